[src/union_find_by_size_core_defines.svh]
// ----------------------------------------------------------------------------
// Union-find core: assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_BY_SIZE_CORE_DEFINES_SVH
`define UNION_FIND_BY_SIZE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ufs_pkg.sv]
// ----------------------------------------------------------------------------
// Union-find package
// Field widths, request codes and the memory control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufs_pkg;

  // Field widths
  localparam int unsigned NODE_W = 10;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned REQ_W  = 2;

  // Default forest depth
  localparam int unsigned MAX_NODES_DEF = 1024;

  // Reset value of the highest-node register
  localparam logic [NODE_W-1:0] HIGHEST_RST = 10'd1023;

  // Size of a singleton set
  localparam logic [SIZE_W-1:0] SIZE_ONE = 11'd1;

  // Request codes (the unused code behaves as a query)
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UNION = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Write enables from the sequencer to the store
  typedef struct packed {
    logic p_we;
    logic s_we;
  } ufs_mem_ctl_t;

endpackage

`default_nettype wire

[src/union_find_by_size_core.sv]
// ----------------------------------------------------------------------------
// Union-find core (union by size, path compression)
// Disjoint-set forest over MAX_NODES nodes with query, union and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: start, req_type_i, node_a_i, node_b_i. A transaction is
//   taken at a clock edge with start high and busy low.
//   Result channel: done_o pulses for one cycle with root_a_o, root_b_o,
//   same_set_o, merged_o, set_size_o and error_o; one result per request.
//   Config: highest_node written through cfg_we_i / cfg_wdata_i while idle.
// Steps: a bad index reports straight from idle; a query walks and then
//   compresses node_a's path, then node_b's, and reads root a's size; a union
//   of two sets also links the roots; clear writes each row, one per cycle.
// Throughput: one request at a time; the parent-memory read loop sets the
//   pace, one chain step per cycle during both the walk and the compression.
//   busy falls in the cycle done_o is shown, so the next request may follow.
// Reset: a clearing pass writes every parent and size entry with busy high;
//   highest_node returns to 1023.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module union_find_by_size_core #(
  parameter int unsigned MAX_NODES = ufs_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ufs_pkg::NODE_W-1:0] cfg_wdata_i,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ufs_pkg::REQ_W-1:0]  req_type_i,
  input  wire logic [ufs_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [ufs_pkg::NODE_W-1:0] node_b_i,
  output logic                            done_o,
  output logic      [ufs_pkg::NODE_W-1:0] root_a_o,
  output logic      [ufs_pkg::NODE_W-1:0] root_b_o,
  output logic                            same_set_o,
  output logic                            merged_o,
  output logic      [ufs_pkg::SIZE_W-1:0] set_size_o,
  output logic                            error_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  logic [ufs_pkg::NODE_W-1:0] highest_q;
  ufs_pkg::ufs_mem_ctl_t      mem_ctl;
  logic [AW-1:0]              p_waddr;
  logic [AW-1:0]              p_wdata;
  logic [AW-1:0]              p_raddr;
  logic [AW-1:0]              p_rdata;
  logic [AW-1:0]              s_waddr;
  logic [ufs_pkg::SIZE_W-1:0] s_wdata;
  logic [AW-1:0]              s_raddr;
  logic [ufs_pkg::SIZE_W-1:0] s_rdata;

  // highest_node register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= ufs_pkg::HIGHEST_RST;
    end else if (cfg_we_i) begin
      highest_q <= cfg_wdata_i;
    end
  end

  ufs_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_ufs_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .highest_i  (highest_q),
    .start_i    (start),
    .busy_o     (busy),
    .req_type_i (req_type_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .done_o     (done_o),
    .root_a_o   (root_a_o),
    .root_b_o   (root_b_o),
    .same_set_o (same_set_o),
    .merged_o   (merged_o),
    .set_size_o (set_size_o),
    .error_o    (error_o),
    .mem_ctl_o  (mem_ctl),
    .p_waddr_o  (p_waddr),
    .p_wdata_o  (p_wdata),
    .p_raddr_o  (p_raddr),
    .p_rdata_i  (p_rdata),
    .s_waddr_o  (s_waddr),
    .s_wdata_o  (s_wdata),
    .s_raddr_o  (s_raddr),
    .s_rdata_i  (s_rdata)
  );

  ufs_store #(
    .MAX_NODES (MAX_NODES)
  ) u_ufs_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .p_waddr_i (p_waddr),
    .p_wdata_i (p_wdata),
    .p_raddr_i (p_raddr),
    .p_rdata_o (p_rdata),
    .s_waddr_i (s_waddr),
    .s_wdata_i (s_wdata),
    .s_raddr_i (s_raddr),
    .s_rdata_o (s_rdata)
  );

endmodule

`default_nettype wire

[src/ufs_store.sv]
// ----------------------------------------------------------------------------
// Union-find store
// Parent and set-size memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufs_store #(
  parameter int unsigned MAX_NODES = ufs_pkg::MAX_NODES_DEF
) (
  input  wire logic                         clk_i,
  input  wire ufs_pkg::ufs_mem_ctl_t        ctl_i,
  input  wire logic [$clog2(MAX_NODES)-1:0] p_waddr_i,
  input  wire logic [$clog2(MAX_NODES)-1:0] p_wdata_i,
  input  wire logic [$clog2(MAX_NODES)-1:0] p_raddr_i,
  output logic      [$clog2(MAX_NODES)-1:0] p_rdata_o,
  input  wire logic [$clog2(MAX_NODES)-1:0] s_waddr_i,
  input  wire logic [ufs_pkg::SIZE_W-1:0]   s_wdata_i,
  input  wire logic [$clog2(MAX_NODES)-1:0] s_raddr_i,
  output logic      [ufs_pkg::SIZE_W-1:0]   s_rdata_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  logic [AW-1:0]              parent_mem [MAX_NODES];
  logic [ufs_pkg::SIZE_W-1:0] size_mem   [MAX_NODES];
  logic [AW-1:0]              p_rdata_q;
  logic [ufs_pkg::SIZE_W-1:0] s_rdata_q;

  // Parent memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.p_we) begin
      parent_mem[p_waddr_i] <= p_wdata_i;
    end
    p_rdata_q <= parent_mem[p_raddr_i];
  end

  // Size memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.s_we) begin
      size_mem[s_waddr_i] <= s_wdata_i;
    end
    s_rdata_q <= size_mem[s_raddr_i];
  end

  assign p_rdata_o = p_rdata_q;
  assign s_rdata_o = s_rdata_q;

endmodule

`default_nettype wire

[src/ufs_seq.sv]
// ----------------------------------------------------------------------------
// Union-find sequencer
// Walks parent chains, compresses paths and links roots, one memory access
// per port per cycle, with one shared compare/add unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufs_seq #(
  parameter int unsigned MAX_NODES = ufs_pkg::MAX_NODES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ufs_pkg::NODE_W-1:0]   highest_i,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [ufs_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [ufs_pkg::NODE_W-1:0]   node_a_i,
  input  wire logic [ufs_pkg::NODE_W-1:0]   node_b_i,
  output logic                              done_o,
  output logic      [ufs_pkg::NODE_W-1:0]   root_a_o,
  output logic      [ufs_pkg::NODE_W-1:0]   root_b_o,
  output logic                              same_set_o,
  output logic                              merged_o,
  output logic      [ufs_pkg::SIZE_W-1:0]   set_size_o,
  output logic                              error_o,
  output ufs_pkg::ufs_mem_ctl_t             mem_ctl_o,
  output logic      [$clog2(MAX_NODES)-1:0] p_waddr_o,
  output logic      [$clog2(MAX_NODES)-1:0] p_wdata_o,
  output logic      [$clog2(MAX_NODES)-1:0] p_raddr_o,
  input  wire logic [$clog2(MAX_NODES)-1:0] p_rdata_i,
  output logic      [$clog2(MAX_NODES)-1:0] s_waddr_o,
  output logic      [ufs_pkg::SIZE_W-1:0]   s_wdata_o,
  output logic      [$clog2(MAX_NODES)-1:0] s_raddr_o,
  input  wire logic [ufs_pkg::SIZE_W-1:0]   s_rdata_i
);

  localparam int unsigned   AW       = $clog2(MAX_NODES);
  localparam int unsigned   SW       = ufs_pkg::SIZE_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_FA_WALK = 8'b0000_0100,
    S_FA_COMP = 8'b0000_1000,
    S_FB_WALK = 8'b0001_0000,
    S_FB_COMP = 8'b0010_0000,
    S_SZ_A    = 8'b0100_0000,
    S_SZ_B    = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          clr_q, clr_d;
  logic          done_q, done_d;

  logic          union_q, union_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] b_q, b_d;
  logic [AW-1:0] r_q, r_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] ra_q, ra_d;
  logic [SW-1:0] sa_q, sa_d;

  logic [ufs_pkg::NODE_W-1:0] root_a_q, root_a_d;
  logic [ufs_pkg::NODE_W-1:0] root_b_q, root_b_d;
  logic                       same_q, same_d;
  logic                       merged_q, merged_d;
  logic [SW-1:0]              size_q, size_d;
  logic                       err_q, err_d;

  logic          bad_idx;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic          at_root;
  logic          path_end;
  logic [SW:0]   sum_full;
  logic [SW-1:0] sum_sat;
  logic          a_smaller;
  logic          roots_eq;

  // Index range check and address conversion
  assign bad_idx = (node_a_i > highest_i) || (node_b_i > highest_i) ||
                   (32'(node_a_i) >= MAX_NODES) || (32'(node_b_i) >= MAX_NODES);
  assign a_addr  = AW'(node_a_i);
  assign b_addr  = AW'(node_b_i);

  // Shared compare/add unit
  assign at_root   = (p_rdata_i == r_q);
  assign path_end  = (cur_q == r_q);
  assign roots_eq  = (ra_q == r_q);
  assign sum_full  = {1'b0, sa_q} + {1'b0, s_rdata_i};
  assign sum_sat   = sum_full[SW] ? {SW{1'b1}} : sum_full[SW-1:0];
  assign a_smaller = (sa_q < s_rdata_i);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    done_d   = 1'b0;
    union_d  = union_q;
    a_d      = a_q;
    b_d      = b_q;
    r_d      = r_q;
    cur_d    = cur_q;
    ra_d     = ra_q;
    sa_d     = sa_q;
    root_a_d = root_a_q;
    root_b_d = root_b_q;
    same_d   = same_q;
    merged_d = merged_q;
    size_d   = size_q;
    err_d    = err_q;

    mem_ctl_o = '0;
    p_waddr_o = cur_q;
    p_wdata_o = r_q;
    p_raddr_o = r_q;
    s_waddr_o = ra_q;
    s_wdata_o = sum_sat;
    s_raddr_o = ra_q;

    case (state_q)
      // Clearing pass: every node its own root with size one
      S_INIT: begin
        mem_ctl_o.p_we = 1'b1;
        mem_ctl_o.s_we = 1'b1;
        p_waddr_o      = cnt_q;
        p_wdata_o      = cnt_q;
        s_waddr_o      = cnt_q;
        s_wdata_o      = ufs_pkg::SIZE_ONE;
        if (cnt_q == LAST_IDX) begin
          state_d = S_IDLE;
          if (clr_q) begin
            clr_d    = 1'b0;
            done_d   = 1'b1;
            root_a_d = '0;
            root_b_d = '0;
            same_d   = 1'b0;
            merged_d = 1'b0;
            size_d   = ufs_pkg::SIZE_ONE;
            err_d    = 1'b0;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      // Wait for a request; start the walk from node_a
      S_IDLE: begin
        p_raddr_o = a_addr;
        if (start_i) begin
          if (req_type_i == ufs_pkg::REQ_CLEAR) begin
            state_d = S_INIT;
            cnt_d   = '0;
            clr_d   = 1'b1;
          end else if (bad_idx) begin
            done_d   = 1'b1;
            root_a_d = '0;
            root_b_d = '0;
            same_d   = 1'b0;
            merged_d = 1'b0;
            size_d   = '0;
            err_d    = 1'b1;
          end else begin
            union_d = (req_type_i == ufs_pkg::REQ_UNION);
            a_d     = a_addr;
            b_d     = b_addr;
            r_d     = a_addr;
            state_d = S_FA_WALK;
          end
        end
      end

      // Follow parents of node_a to the root
      S_FA_WALK: begin
        if (at_root) begin
          cur_d     = a_q;
          p_raddr_o = a_q;
          state_d   = S_FA_COMP;
        end else begin
          r_d       = p_rdata_i;
          p_raddr_o = p_rdata_i;
        end
      end

      // Point every node on node_a's path at its root
      S_FA_COMP: begin
        if (path_end) begin
          ra_d      = r_q;
          r_d       = b_q;
          p_raddr_o = b_q;
          state_d   = S_FB_WALK;
        end else begin
          mem_ctl_o.p_we = 1'b1;
          cur_d          = p_rdata_i;
          p_raddr_o      = p_rdata_i;
        end
      end

      // Follow parents of node_b to the root
      S_FB_WALK: begin
        if (at_root) begin
          cur_d     = b_q;
          p_raddr_o = b_q;
          state_d   = S_FB_COMP;
        end else begin
          r_d       = p_rdata_i;
          p_raddr_o = p_rdata_i;
        end
      end

      // Compress node_b's path, then fetch the size of root a
      S_FB_COMP: begin
        if (path_end) begin
          s_raddr_o = ra_q;
          state_d   = S_SZ_A;
        end else begin
          mem_ctl_o.p_we = 1'b1;
          cur_d          = p_rdata_i;
          p_raddr_o      = p_rdata_i;
        end
      end

      // Size of root a available; finish or fetch size of root b
      S_SZ_A: begin
        root_a_d = ufs_pkg::NODE_W'(ra_q);
        root_b_d = ufs_pkg::NODE_W'(r_q);
        same_d   = roots_eq;
        err_d    = 1'b0;
        if (union_q && !roots_eq) begin
          sa_d      = s_rdata_i;
          s_raddr_o = r_q;
          state_d   = S_SZ_B;
        end else begin
          merged_d = 1'b0;
          size_d   = s_rdata_i;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Link the smaller root under the larger; ties keep root a
      S_SZ_B: begin
        mem_ctl_o.p_we = 1'b1;
        mem_ctl_o.s_we = 1'b1;
        s_wdata_o      = sum_sat;
        if (a_smaller) begin
          p_waddr_o = ra_q;
          p_wdata_o = r_q;
          s_waddr_o = r_q;
        end else begin
          p_waddr_o = r_q;
          p_wdata_o = ra_q;
          s_waddr_o = ra_q;
        end
        merged_d = 1'b1;
        size_d   = sum_sat;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      clr_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    union_q  <= union_d;
    a_q      <= a_d;
    b_q      <= b_d;
    r_q      <= r_d;
    cur_q    <= cur_d;
    ra_q     <= ra_d;
    sa_q     <= sa_d;
    root_a_q <= root_a_d;
    root_b_q <= root_b_d;
    same_q   <= same_d;
    merged_q <= merged_d;
    size_q   <= size_d;
    err_q    <= err_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign root_a_o   = root_a_q;
  assign root_b_o   = root_b_q;
  assign same_set_o = same_q;
  assign merged_o   = merged_q;
  assign set_size_o = size_q;
  assign error_o    = err_q;

endmodule

`default_nettype wire

[src/ufs_checker.sv]
// ----------------------------------------------------------------------------
// Union-find port checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "union_find_by_size_core_defines.svh"

module ufs_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_i,
  input wire logic                       done_i,
  input wire logic [ufs_pkg::NODE_W-1:0] root_a_i,
  input wire logic [ufs_pkg::NODE_W-1:0] root_b_i,
  input wire logic                       same_set_i,
  input wire logic                       merged_i,
  input wire logic [ufs_pkg::SIZE_W-1:0] set_size_i,
  input wire logic                       error_i
);

  // An accepted transaction either goes busy or reports at once
  `UFS_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_i, busy_i || done_i, "accepted request neither busy nor done")

  // A flagged request reports all-zero fields
  `UFS_ASSERT_NOW(a_error_zero, clk_i, rst_ni, done_i && error_i, root_a_i == '0 && root_b_i == '0 && !same_set_i && !merged_i && set_size_i == '0, "error result carries nonzero fields")

  // A good result always has a nonempty set
  `UFS_ASSERT_NOW(a_size_nonzero, clk_i, rst_ni, done_i && !error_i, set_size_i != '0, "good result with zero set size")

  // A merge only joins distinct roots
  `UFS_ASSERT_NOW(a_merge_distinct, clk_i, rst_ni, done_i && merged_i, !same_set_i && !error_i && root_a_i != root_b_i, "merge reported on one set")

  // Same-set flag agrees with the reported roots
  `UFS_ASSERT_NOW(a_same_roots, clk_i, rst_ni, done_i && same_set_i, root_a_i == root_b_i, "same_set with different roots")

endmodule

bind union_find_by_size_core ufs_checker u_ufs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .busy_i     (busy),
  .done_i     (done_o),
  .root_a_i   (root_a_o),
  .root_b_i   (root_b_o),
  .same_set_i (same_set_o),
  .merged_i   (merged_o),
  .set_size_i (set_size_o),
  .error_i    (error_o)
);

`default_nettype wire

[bench/ufs_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Union-find testbench scoreboard
// Predicts each result of the union-find core from its own disjoint-set
// forest and checks the results the core shows against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ufs_tb_pkg;

  import ufs_pkg::*;

  // One result transaction as seen on the result ports
  typedef struct packed {
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    logic              same_set;
    logic              merged;
    logic [SIZE_W-1:0] set_size;
    logic              error;
  } uf_outcome_t;

  localparam int unsigned SIZE_SAT = (1 << SIZE_W) - 1;

  class ufs_scoreboard;
    bit [NODE_W-1:0] link_tbl [MAX_NODES_DEF];
    int unsigned     weight_tbl [MAX_NODES_DEF];
    bit [NODE_W-1:0] highest;
    uf_outcome_t     pending_q [$];
    int unsigned     errors;

    function new();
      make_singletons();
      highest = HIGHEST_RST;
      errors  = 0;
    endfunction

    function void make_singletons();
      for (int i = 0; i < MAX_NODES_DEF; i++) begin
        link_tbl[i]   = NODE_W'(i);
        weight_tbl[i] = 1;
      end
    endfunction

    function void set_highest(bit [NODE_W-1:0] value);
      highest = value;
    endfunction

    // Walk to the root, then point every node on the path straight at it
    function bit [NODE_W-1:0] find_root(bit [NODE_W-1:0] node);
      bit [NODE_W-1:0] root;
      bit [NODE_W-1:0] cur;
      bit [NODE_W-1:0] nxt;
      int              steps;
      root  = node;
      steps = 0;
      while (steps < MAX_NODES_DEF && link_tbl[root] != root) begin
        root = link_tbl[root];
        steps++;
      end
      cur   = node;
      steps = 0;
      while (cur != root && steps < MAX_NODES_DEF) begin
        nxt           = link_tbl[cur];
        link_tbl[cur] = root;
        cur           = nxt;
        steps++;
      end
      return root;
    endfunction

    // Accepted request transaction: update the forest, queue the result
    function void note_request(logic [REQ_W-1:0] req, logic [NODE_W-1:0] a,
                               logic [NODE_W-1:0] b);
      uf_outcome_t     want;
      bit [NODE_W-1:0] ra;
      bit [NODE_W-1:0] rb;
      int unsigned     sz;
      want = '0;
      if (req == REQ_CLEAR) begin
        make_singletons();
        want.set_size = SIZE_ONE;
      end else if (a > highest || b > highest) begin
        want.error = 1'b1;
      end else begin
        ra = find_root(a);
        rb = find_root(b);
        want.root_a   = ra;
        want.root_b   = rb;
        want.same_set = (ra == rb);
        if (req == REQ_UNION && ra != rb) begin
          // smaller set goes under the larger; a tie keeps node_a's root
          if (weight_tbl[ra] < weight_tbl[rb]) begin
            link_tbl[ra]    = rb;
            weight_tbl[rb] += weight_tbl[ra];
            sz              = weight_tbl[rb];
          end else begin
            link_tbl[rb]    = ra;
            weight_tbl[ra] += weight_tbl[rb];
            sz              = weight_tbl[ra];
          end
          want.merged = 1'b1;
        end else begin
          sz = weight_tbl[ra];
        end
        want.set_size = SIZE_W'((sz > SIZE_SAT) ? SIZE_SAT : sz);
      end
      pending_q.insert(pending_q.size(), want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Result transaction: compare against the oldest prediction
    task check_result(uf_outcome_t got);
      uf_outcome_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_q.pop_front();
        compare_field("root_a",   16'(got.root_a),   16'(want.root_a));
        compare_field("root_b",   16'(got.root_b),   16'(want.root_b));
        compare_field("same_set", 16'(got.same_set), 16'(want.same_set));
        compare_field("merged",   16'(got.merged),   16'(want.merged));
        compare_field("set_size", 16'(got.set_size), 16'(want.set_size));
        compare_field("error",    16'(got.error),    16'(want.error));
      end
    endtask
  endclass

endpackage

[bench/tb_union_find_by_size_core.sv]
// ----------------------------------------------------------------------------
// Union-find core testbench
// Directed requests over the corner cases (extreme indices, ties, chains,
// clears, out-of-range nodes, lowered highest_node), then random request
// streams in several highest_node settings and sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_union_find_by_size_core;

  import ufs_pkg::*;
  import ufs_tb_pkg::*;

  // Unused request code, decoded as a query
  localparam logic [REQ_W-1:0] REQ_ALIAS = 2'd3;
  localparam logic [NODE_W-1:0] NODE_TOP = '1;
  // Quiet cycles allowed: covers the reset and clear passes several times
  localparam int unsigned QUIET_LIMIT = 5000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [NODE_W-1:0] cfg_wdata_i;
  logic              start;
  logic              busy;
  logic [REQ_W-1:0]  req_type_i;
  logic [NODE_W-1:0] node_a_i;
  logic [NODE_W-1:0] node_b_i;
  logic              done_o;
  logic [NODE_W-1:0] root_a_o;
  logic [NODE_W-1:0] root_b_o;
  logic              same_set_o;
  logic              merged_o;
  logic [SIZE_W-1:0] set_size_o;
  logic              error_o;

  ufs_scoreboard sb;
  uf_outcome_t   seen;
  int unsigned   idle_pct;
  int unsigned   quiet_cycles = 0;

  union_find_by_size_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .done_o      (done_o),
    .root_a_o    (root_a_o),
    .root_b_o    (root_b_o),
    .same_set_o  (same_set_o),
    .merged_o    (merged_o),
    .set_size_o  (set_size_o),
    .error_o     (error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: check a result before noting a request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        seen.root_a   = root_a_o;
        seen.root_b   = root_b_o;
        seen.same_set = same_set_o;
        seen.merged   = merged_o;
        seen.set_size = set_size_o;
        seen.error    = error_o;
        sb.check_result(seen);
      end
      if (start && !busy)
        sb.note_request(req_type_i, node_a_i, node_b_i);
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one request, idling first at random, until it is taken
  task send_request(logic [REQ_W-1:0] req, logic [NODE_W-1:0] a,
                    logic [NODE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    node_a_i   <= a;
    node_b_i   <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start and wait until every queued result has come back
  task wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  task write_highest(logic [NODE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_highest(value);
  endtask

  // Mostly nodes from a small window so sets grow and chains form;
  // some from the whole valid range and some out of range
  function automatic logic [NODE_W-1:0] pick_node(int unsigned lo, int unsigned hi_w,
                                                  int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5 && hi < NODE_TOP)
      return NODE_W'($urandom_range(NODE_TOP, hi + 1));
    if (r < 15)
      return NODE_W'($urandom_range(hi, 0));
    return NODE_W'($urandom_range(hi_w, lo));
  endfunction

  task run_random(int unsigned count, int unsigned pct, logic [NODE_W-1:0] hi);
    int unsigned      span;
    int unsigned      lo_w;
    int unsigned      r;
    logic [REQ_W-1:0] req;
    lo_w = 0;
    span = 0;
    wait_idle();
    write_highest(hi);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        span = $urandom_range(40, 6);
        if (span > hi) span = hi;
        lo_w = $urandom_range(hi - span, 0);
      end
      r = $urandom_range(99);
      if (r < 2)       req = REQ_CLEAR;
      else if (r < 50) req = REQ_UNION;
      else if (r < 56) req = REQ_ALIAS;
      else             req = REQ_QUERY;
      send_request(req, pick_node(lo_w, lo_w + span, hi), pick_node(lo_w, lo_w + span, hi));
    end
  endtask

  initial begin
    sb = new();
    start       <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    req_type_i  <= REQ_QUERY;
    node_a_i    <= '0;
    node_b_i    <= '0;
    idle_pct    = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset clears the forest with busy high
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    write_highest(HIGHEST_RST);

    // extremes, tie, chains and compression
    send_request(REQ_QUERY, 10'd0, NODE_TOP);
    send_request(REQ_UNION, 10'd0, NODE_TOP);
    send_request(REQ_UNION, NODE_TOP, 10'd0);
    send_request(REQ_ALIAS, NODE_TOP, 10'd0);
    send_request(REQ_UNION, 10'd5, 10'd6);
    send_request(REQ_UNION, 10'd7, 10'd5);
    send_request(REQ_UNION, 10'd8, 10'd9);
    send_request(REQ_UNION, 10'd9, 10'd7);
    send_request(REQ_QUERY, 10'd9, 10'd6);
    send_request(REQ_UNION, NODE_TOP, 10'd5);
    send_request(REQ_QUERY, NODE_TOP, NODE_TOP);
    send_request(REQ_UNION, 10'd900, 10'd10);
    // clear ignores its node fields
    send_request(REQ_CLEAR, NODE_TOP, NODE_TOP);
    send_request(REQ_QUERY, 10'd900, 10'd10);
    send_request(REQ_UNION, 10'd900, 10'd10);

    // lowered highest_node: node 10 keeps its root above the limit
    wait_idle();
    write_highest(10'd500);
    send_request(REQ_QUERY, 10'd10, 10'd11);
    send_request(REQ_UNION, 10'd10, 10'd501);
    send_request(REQ_QUERY, 10'd501, 10'd10);

    // single node in use
    wait_idle();
    write_highest(10'd0);
    send_request(REQ_QUERY, 10'd0, 10'd0);
    send_request(REQ_UNION, 10'd0, 10'd0);
    send_request(REQ_QUERY, NODE_TOP, 10'd0);
    send_request(REQ_CLEAR, NODE_TOP, NODE_TOP);

    run_random(200, 7, HIGHEST_RST);
    run_random(200, 51, NODE_W'($urandom_range(1022, 300)));
    run_random(200, 0, 10'd127);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
